// ===== hw/rtl/uvs_pkg.sv =====
package uvs_pkg;

    localparam int CNT_W      = 11;
    localparam int RAD_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IDX_W      = 11;
    localparam int ANG_W      = 61;
    localparam int CS_W       = 32;
    localparam int CX_W       = 34;
    localparam int Z_W        = 64;
    localparam int POS_W      = 17;
    localparam int NRM_W      = 16;
    localparam int TEX_W      = 17;
    localparam int TNUM_W     = CNT_W + 16;
    localparam int QNUM_W     = CNT_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_RADIUS = 2'd2;

    // pi/2 in Q1.60.
    localparam logic [ANG_W-1:0] PI_HALF_Q60 = 61'h1921FB54442D1846;
    localparam logic signed [CX_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CX_W-1:0] ONE_Q30  = 34'sd1073741824;

    typedef struct packed {
        logic signed [CS_W-1:0] cos_v;
        logic signed [CS_W-1:0] sin_v;
    } t_sincos;

    // atan(2^-i) in Q3.60: pi/4 for i = 0, else from the power series, each term truncated.
    // Evaluated at elaboration only; the term division is a bit-serial loop.
    function automatic logic signed [Z_W-1:0] atan_step(input int i);
        logic [63:0] sum;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] den;
        int n;
        int sh;
        int b;
        sum = '0;
        if (i == 0) begin
            sum = {3'b000, PI_HALF_Q60} >> 1;
        end else begin
            for (n = 0; n < 61; n++) begin
                sh = i * (2 * n + 1);
                if (sh <= 60) begin
                    num = 64'd1 << (60 - sh);
                    den = 64'(2 * n + 1);
                    rem = '0;
                    quo = '0;
                    for (b = 63; b >= 0; b--) begin
                        rem = {rem[62:0], num[b]};
                        if (rem >= den) begin
                            rem = rem - den;
                            quo[b] = 1'b1;
                        end
                    end
                    if (n[0]) begin
                        sum = sum - quo;
                    end else begin
                        sum = sum + quo;
                    end
                end
            end
        end
        return signed'(sum);
    endfunction

endpackage

// ===== hw/rtl/uvs_sincos.sv =====
module uvs_sincos #(
    parameter int NUM_W         = 13,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [NUM_W-1:0]                i_num,
    input  logic [uvs_pkg::CNT_W-1:0]       i_den,
    output uvs_pkg::t_sincos                o_sc
);

    localparam int CNT_W = uvs_pkg::CNT_W;
    localparam int ANG_W = uvs_pkg::ANG_W;
    localparam int CX_W  = uvs_pkg::CX_W;
    localparam int Z_W   = uvs_pkg::Z_W;
    localparam int CS_W  = uvs_pkg::CS_W;

    // Quadrant division: n / d, keeping the remainder and the low two quotient bits.
    logic [NUM_W-1:0] r_qd_num [NUM_W];
    logic [CNT_W-1:0] r_qd_rem [NUM_W];
    logic [1:0]       r_qd_q   [NUM_W];

    for (genvar j = 0; j < NUM_W; j++) begin : g_qd
        logic [NUM_W-1:0] num_in;
        logic [CNT_W-1:0] rem_in;
        logic [1:0]       q_in;
        logic [CNT_W:0]   t;
        logic             ge;
        if (j == 0) begin : g_first
            assign num_in = i_num;
            assign rem_in = '0;
            assign q_in   = '0;
        end else begin : g_next
            assign num_in = r_qd_num[j-1];
            assign rem_in = r_qd_rem[j-1];
            assign q_in   = r_qd_q[j-1];
        end
        always_comb begin
            t  = {rem_in, num_in[NUM_W-1]};
            ge = (t >= {1'b0, i_den});
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_qd_num[j] <= {num_in[NUM_W-2:0], 1'b0};
                r_qd_rem[j] <= ge ? CNT_W'(t - {1'b0, i_den}) : t[CNT_W-1:0];
                r_qd_q[j]   <= {q_in[0], ge};
            end
        end
    end

    // Residual angle floor(pi/2 * r / d), one bit of the constant per stage.
    // Each step adds r or not, so the quotient digit is 0, 1 or 2.
    logic [CNT_W-1:0] r_ad_rem  [ANG_W];
    logic [CNT_W-1:0] r_ad_r    [ANG_W];
    logic [ANG_W-1:0] r_ad_quo  [ANG_W];
    logic [1:0]       r_ad_q    [ANG_W];
    logic             r_ad_zero [ANG_W];

    for (genvar m = 0; m < ANG_W; m++) begin : g_ad
        localparam logic ABIT = uvs_pkg::PI_HALF_Q60[ANG_W-1-m];
        logic [CNT_W-1:0] rem_in;
        logic [CNT_W-1:0] r_in;
        logic [ANG_W-1:0] quo_in;
        logic [1:0]       q_in;
        logic             zero_in;
        logic [CNT_W+1:0] t;
        logic [CNT_W+1:0] d1;
        logic [CNT_W+1:0] d2;
        logic [CNT_W+1:0] t_next;
        logic [1:0]       digit;
        if (m == 0) begin : g_first
            assign rem_in  = '0;
            assign r_in    = r_qd_rem[NUM_W-1];
            assign quo_in  = '0;
            assign q_in    = r_qd_q[NUM_W-1];
            assign zero_in = (r_qd_rem[NUM_W-1] == '0);
        end else begin : g_next
            assign rem_in  = r_ad_rem[m-1];
            assign r_in    = r_ad_r[m-1];
            assign quo_in  = r_ad_quo[m-1];
            assign q_in    = r_ad_q[m-1];
            assign zero_in = r_ad_zero[m-1];
        end
        always_comb begin
            d1 = {2'b00, i_den};
            d2 = {1'b0, i_den, 1'b0};
            t  = {1'b0, rem_in, 1'b0} + (ABIT ? {2'b00, r_in} : '0);
            if (t >= d2) begin
                digit  = 2'd2;
                t_next = t - d2;
            end else if (t >= d1) begin
                digit  = 2'd1;
                t_next = t - d1;
            end else begin
                digit  = 2'd0;
                t_next = t;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ad_rem[m]  <= t_next[CNT_W-1:0];
                r_ad_r[m]    <= r_in;
                r_ad_quo[m]  <= {quo_in[ANG_W-2:0], 1'b0} + ANG_W'(digit);
                r_ad_q[m]    <= q_in;
                r_ad_zero[m] <= zero_in;
            end
        end
    end

    // Rotation-mode CORDIC, one micro-rotation per stage.
    logic signed [CX_W-1:0] r_cx    [CORDIC_STAGES];
    logic signed [CX_W-1:0] r_cy    [CORDIC_STAGES];
    logic signed [Z_W-1:0]  r_cz    [CORDIC_STAGES];
    logic [1:0]             r_cq    [CORDIC_STAGES];
    logic                   r_czero [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        localparam logic signed [Z_W-1:0] ATAN_I = uvs_pkg::atan_step(i);
        logic signed [CX_W-1:0] x_in;
        logic signed [CX_W-1:0] y_in;
        logic signed [Z_W-1:0]  z_in;
        logic [1:0]             q_in;
        logic                   zero_in;
        logic signed [CX_W-1:0] dx;
        logic signed [CX_W-1:0] dy;
        if (i == 0) begin : g_first
            assign x_in    = uvs_pkg::GAIN_Q30;
            assign y_in    = '0;
            assign z_in    = signed'(Z_W'(r_ad_quo[ANG_W-1]));
            assign q_in    = r_ad_q[ANG_W-1];
            assign zero_in = r_ad_zero[ANG_W-1];
        end else begin : g_next
            assign x_in    = r_cx[i-1];
            assign y_in    = r_cy[i-1];
            assign z_in    = r_cz[i-1];
            assign q_in    = r_cq[i-1];
            assign zero_in = r_czero[i-1];
        end
        always_comb begin
            dx = y_in >>> i;
            dy = x_in >>> i;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!z_in[Z_W-1]) begin
                    r_cx[i] <= x_in - dx;
                    r_cy[i] <= y_in + dy;
                    r_cz[i] <= z_in - ATAN_I;
                end else begin
                    r_cx[i] <= x_in + dx;
                    r_cy[i] <= y_in - dy;
                    r_cz[i] <= z_in + ATAN_I;
                end
                r_cq[i]    <= q_in;
                r_czero[i] <= zero_in;
            end
        end
    end

    // Saturate, handle the exact-multiple case and map the quadrant.
    logic signed [CX_W-1:0] c_sat;
    logic signed [CX_W-1:0] s_sat;
    logic signed [CS_W-1:0] c_v;
    logic signed [CS_W-1:0] s_v;
    uvs_pkg::t_sincos       n_sc;
    uvs_pkg::t_sincos       r_sc;

    always_comb begin
        c_sat = r_cx[CORDIC_STAGES-1];
        s_sat = r_cy[CORDIC_STAGES-1];
        if (c_sat > uvs_pkg::ONE_Q30) c_sat = uvs_pkg::ONE_Q30;
        if (c_sat < -uvs_pkg::ONE_Q30) c_sat = -uvs_pkg::ONE_Q30;
        if (s_sat > uvs_pkg::ONE_Q30) s_sat = uvs_pkg::ONE_Q30;
        if (s_sat < -uvs_pkg::ONE_Q30) s_sat = -uvs_pkg::ONE_Q30;
        if (r_czero[CORDIC_STAGES-1]) begin
            c_sat = uvs_pkg::ONE_Q30;
            s_sat = '0;
        end
        c_v = c_sat[CS_W-1:0];
        s_v = s_sat[CS_W-1:0];
        case (r_cq[CORDIC_STAGES-1])
            2'd0: begin
                n_sc.cos_v = c_v;
                n_sc.sin_v = s_v;
            end
            2'd1: begin
                n_sc.cos_v = -s_v;
                n_sc.sin_v = c_v;
            end
            2'd2: begin
                n_sc.cos_v = -c_v;
                n_sc.sin_v = -s_v;
            end
            default: begin
                n_sc.cos_v = s_v;
                n_sc.sin_v = -c_v;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sc <= n_sc;
        end
    end

    assign o_sc = r_sc;

endmodule

// ===== hw/rtl/uv_sphere_vertex_generator.sv =====
// UV sphere vertex generator.
// The slave stream takes one grid point (stack index, sector index) per
// transaction; the master stream returns its vertex: position, unit normal and
// texture coordinates, one result transaction per input transaction, in order.
// The configuration channel writes stack_count (0), sector_count (1) and
// sphere_radius (2); it is always ready, and other indexes are ignored. Write
// it only while no vertex is in flight.
// Throughput is one vertex per cycle while the receiver keeps taking results.
// Each input passes through the quadrant divider, the 61-step residual-angle
// divider and the CORDIC chain, all one step per stage, followed by four
// stages of multiplies, rounding and saturation.
// Reset restores stack_count 16, sector_count 32, radius 1.0 and empties the
// pipeline. When the receiver stalls with a result waiting, the whole pipeline
// holds and o_s_tready drops; nothing is lost or repeated.
module uv_sphere_vertex_generator #(
    parameter int MAX_DIVISIONS = 1024,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // [10:0] stack_index, [21:11] sector_index, [23:22] zero
    input  logic [23:0]                        i_s_tdata,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [16:0] pos_x, [33:17] pos_y, [50:34] pos_z, [66:51] normal_x,
    // [82:67] normal_y, [98:83] normal_z, [115:99] tex_u, [132:116] tex_v,
    // [135:133] zero
    output logic [135:0]                       o_m_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [uvs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [uvs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CNT_W   = uvs_pkg::CNT_W;
    localparam int IDX_W   = uvs_pkg::IDX_W;
    localparam int TNUM_W  = uvs_pkg::TNUM_W;
    localparam int TEX_W   = uvs_pkg::TEX_W;
    localparam int QN_W    = uvs_pkg::QNUM_W;
    localparam int CS_W    = uvs_pkg::CS_W;
    localparam int POS_W   = uvs_pkg::POS_W;
    localparam int NRM_W   = uvs_pkg::NRM_W;
    localparam int RAD_W   = uvs_pkg::RAD_W;
    localparam int PR_W    = RAD_W + 1 + CS_W;
    localparam int LAT     = QN_W + uvs_pkg::ANG_W + CORDIC_STAGES + 1;
    localparam int OUT_LAT = LAT + 4;
    localparam int TEX_DLY = OUT_LAT - TNUM_W;

    // Configuration registers.
    logic [CNT_W-1:0] r_stack_count;
    logic [CNT_W-1:0] r_sector_count;
    logic [RAD_W-1:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_count  <= CNT_W'(16);
            r_sector_count <= CNT_W'(32);
            r_radius       <= RAD_W'(256);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                uvs_pkg::CFG_STACK_COUNT:   r_stack_count  <= i_cfg_data[CNT_W-1:0];
                uvs_pkg::CFG_SECTOR_COUNT:  r_sector_count <= i_cfg_data[CNT_W-1:0];
                uvs_pkg::CFG_SPHERE_RADIUS: r_radius       <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Effective counts, clamped to 1..MAX_DIVISIONS.
    logic [CNT_W-1:0] stack_eff;
    logic [CNT_W-1:0] sector_eff;

    always_comb begin
        if (r_stack_count == '0) begin
            stack_eff = CNT_W'(1);
        end else if (int'(r_stack_count) > MAX_DIVISIONS) begin
            stack_eff = CNT_W'(MAX_DIVISIONS);
        end else begin
            stack_eff = r_stack_count;
        end
        if (r_sector_count == '0) begin
            sector_eff = CNT_W'(1);
        end else if (int'(r_sector_count) > MAX_DIVISIONS) begin
            sector_eff = CNT_W'(MAX_DIVISIONS);
        end else begin
            sector_eff = r_sector_count;
        end
    end

    // Global pipeline advance: the whole pipe holds while a result waits.
    logic [OUT_LAT-1:0] r_vld;
    logic               adv;

    assign adv        = !r_vld[OUT_LAT-1] || i_m_tready;
    assign o_s_tready = adv;
    assign o_m_tvalid = r_vld[OUT_LAT-1];

    // Input stage with index clamping.
    logic             r_in_vld;
    logic [IDX_W-1:0] r_stk;
    logic [IDX_W-1:0] r_sec;
    logic [IDX_W-1:0] stk_in;
    logic [IDX_W-1:0] sec_in;

    always_comb begin
        stk_in = i_s_tdata[IDX_W-1:0];
        sec_in = i_s_tdata[2*IDX_W-1:IDX_W];
        if (stk_in > stack_eff) stk_in = stack_eff;
        if (sec_in > sector_eff) sec_in = sector_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_vld    <= '0;
        end else if (adv) begin
            r_in_vld <= i_s_tvalid;
            r_vld    <= {r_vld[OUT_LAT-2:0], r_in_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_stk <= stk_in;
            r_sec <= sec_in;
        end
    end

    // Stack angle: 2s/sc quarter turns; sector angle: 4k/kc quarter turns.
    uvs_pkg::t_sincos stk_sc;
    uvs_pkg::t_sincos sec_sc;

    uvs_sincos #(
        .NUM_W         (QN_W),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_stack_sincos (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (QN_W'({r_stk, 1'b0})),
        .i_den (stack_eff),
        .o_sc  (stk_sc)
    );

    uvs_sincos #(
        .NUM_W         (QN_W),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_sector_sincos (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (QN_W'({r_sec, 2'b00})),
        .i_den (sector_eff),
        .o_sc  (sec_sc)
    );

    // Texture coordinates: restoring division, lane 0 is u, lane 1 is v.
    logic [TNUM_W-1:0] r_tx_num [2][TNUM_W];
    logic [CNT_W-1:0]  r_tx_rem [2][TNUM_W];
    logic [TEX_W-1:0]  r_tx_quo [2][TNUM_W];

    for (genvar l = 0; l < 2; l++) begin : g_tex
        logic [CNT_W-1:0]  den;
        logic [TNUM_W-1:0] num0;
        if (l == 0) begin : g_u
            assign den  = sector_eff;
            assign num0 = {r_sec, 16'h0000} + TNUM_W'(sector_eff >> 1);
        end else begin : g_v
            assign den  = stack_eff;
            assign num0 = {r_stk, 16'h0000} + TNUM_W'(stack_eff >> 1);
        end
        for (genvar j = 0; j < TNUM_W; j++) begin : g_stage
            logic [TNUM_W-1:0] num_in;
            logic [CNT_W-1:0]  rem_in;
            logic [TEX_W-1:0]  quo_in;
            logic [CNT_W:0]    t;
            logic              ge;
            if (j == 0) begin : g_first
                assign num_in = num0;
                assign rem_in = '0;
                assign quo_in = '0;
            end else begin : g_next
                assign num_in = r_tx_num[l][j-1];
                assign rem_in = r_tx_rem[l][j-1];
                assign quo_in = r_tx_quo[l][j-1];
            end
            always_comb begin
                t  = {rem_in, num_in[TNUM_W-1]};
                ge = (t >= {1'b0, den});
            end
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_tx_num[l][j] <= {num_in[TNUM_W-2:0], 1'b0};
                    r_tx_rem[l][j] <= ge ? CNT_W'(t - {1'b0, den}) : t[CNT_W-1:0];
                    r_tx_quo[l][j] <= {quo_in[TEX_W-2:0], ge};
                end
            end
        end
    end

    logic [2*TEX_W-1:0] r_tex_dly [TEX_DLY];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tex_dly[0] <= {r_tx_quo[1][TNUM_W-1], r_tx_quo[0][TNUM_W-1]};
            for (int d = 1; d < TEX_DLY; d++) begin
                r_tex_dly[d] <= r_tex_dly[d-1];
            end
        end
    end

    // Rounding and saturation helpers.
    function automatic logic signed [CS_W-1:0] fn_r30(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd536870912) >>> 30;
        return t[CS_W-1:0];
    endfunction

    function automatic logic [NRM_W-1:0] fn_nrm(input logic signed [CS_W-1:0] v);
        logic signed [CS_W:0] t;
        t = ((CS_W+1)'(v) + 33'sd32768) >>> 16;
        if (t > 33'sd16384) t = 33'sd16384;
        if (t < -33'sd16384) t = -33'sd16384;
        return t[NRM_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] fn_pos(input logic signed [PR_W-1:0] p);
        logic signed [PR_W-1:0] t;
        t = (p + PR_W'(536870912)) >>> 30;
        if (t > PR_W'(65535)) t = PR_W'(65535);
        if (t < -PR_W'(65535)) t = -PR_W'(65535);
        return t[POS_W-1:0];
    endfunction

    // Products cos(phi) * cos/sin(theta); cos(phi) is the stack sine.
    logic signed [63:0]     r_px;
    logic signed [63:0]     r_pz;
    logic signed [CS_W-1:0] r_p1_vy;
    logic signed [CS_W-1:0] r_vx;
    logic signed [CS_W-1:0] r_vy;
    logic signed [CS_W-1:0] r_vz;
    logic signed [PR_W-1:0] r_qx;
    logic signed [PR_W-1:0] r_qy;
    logic signed [PR_W-1:0] r_qz;
    logic signed [CS_W-1:0] r_v3x;
    logic signed [CS_W-1:0] r_v3y;
    logic signed [CS_W-1:0] r_v3z;
    logic [POS_W-1:0]       r_pos_x;
    logic [POS_W-1:0]       r_pos_y;
    logic [POS_W-1:0]       r_pos_z;
    logic [NRM_W-1:0]       r_nrm_x;
    logic [NRM_W-1:0]       r_nrm_y;
    logic [NRM_W-1:0]       r_nrm_z;
    logic signed [PR_W-1:0] rad_s;

    assign rad_s = signed'(PR_W'(r_radius));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_px    <= 64'(stk_sc.sin_v) * 64'(sec_sc.cos_v);
            r_pz    <= 64'(stk_sc.sin_v) * 64'(sec_sc.sin_v);
            r_p1_vy <= stk_sc.cos_v;

            r_vx <= fn_r30(r_px);
            r_vy <= r_p1_vy;
            r_vz <= fn_r30(r_pz);

            r_qx  <= rad_s * PR_W'(r_vx);
            r_qy  <= rad_s * PR_W'(r_vy);
            r_qz  <= rad_s * PR_W'(r_vz);
            r_v3x <= r_vx;
            r_v3y <= r_vy;
            r_v3z <= r_vz;

            r_pos_x <= fn_pos(r_qx);
            r_pos_y <= fn_pos(r_qy);
            r_pos_z <= fn_pos(r_qz);
            r_nrm_x <= fn_nrm(r_v3x);
            r_nrm_y <= fn_nrm(r_v3y);
            r_nrm_z <= fn_nrm(r_v3z);
        end
    end

    assign o_m_tdata = {3'b000, r_tex_dly[TEX_DLY-1], r_nrm_z, r_nrm_y, r_nrm_x,
                        r_pos_z, r_pos_y, r_pos_x};

endmodule
